// ===== sv/tts_pkg.sv =====
// Shared types, constants and helpers for the timed task slot table.
package tts_pkg;

  localparam int SLOTS       = 4;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 88;

  localparam logic [1:0]  KIND_SUBMIT = 2'd0;
  localparam logic [1:0]  KIND_TICK   = 2'd1;
  localparam logic [1:0]  KIND_REPLY  = 2'd2;
  localparam logic [15:0] RETRY_ONCE  = 16'h0001;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUE      = 3'd2,
    ST_NONE_DUE = 3'd3,
    ST_RESCHED  = 3'd4,
    ST_DELETED  = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  typedef struct packed {
    logic [31:0] run_time;
    logic [15:0] retries;
    logic [15:0] handle;
    logic [31:0] data;
  } slot_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] time_value;
    logic [15:0] retry_count;
    logic [15:0] task_handle;
    logic [31:0] task_data;
    logic [1:0]  reply_slot;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  slot_index;
    logic [15:0] due_handle;
    logic [31:0] scheduled_time;
    logic [31:0] due_data;
    logic        last;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    slot_entry_t      entry;
  } mem_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  function automatic logic [IDX_W-1:0] slot_addr(input logic [1:0] s);
    return IDX_W'(s);
  endfunction

  function automatic logic slot_in_range(input logic [1:0] s);
    return (32'(s) < 32'(SLOTS));
  endfunction

endpackage

// ===== sv/tts_slot_mem.sv =====
// Slot storage: one write port, one read port, registered read data.
module tts_slot_mem import tts_pkg::*; (
  input  logic        clk,
  input  mem_wr_t     wr,
  input  mem_rd_t     rd,
  output slot_entry_t rd_data
);

  slot_entry_t mem_r [SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.entry;
    end
    if (rd.re) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/tts_ctrl.sv =====
// Sequencer: submit, tick scan and reply read-modify-write over the slot memory.
module tts_ctrl import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        in_ready,
  input  logic        res_ready,
  output logic        res_push,
  output result_t     res,
  output mem_wr_t     mem_wr,
  output mem_rd_t     mem_rd,
  input  slot_entry_t mem_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RPL_WR, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  item_t            item_r, item_nxt;
  result_t          res_r, res_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [CNT_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] pend_r, pend_nxt;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             due;
  logic             stall;
  logic             scan_done;
  logic             keep;
  logic [IDX_W-1:0] in_addr;
  logic [IDX_W-1:0] rpl_addr;
  result_t          due_res;

  function automatic result_t mk_result(input status_t st, input logic [1:0] slot);
    result_t r;
    r = '0;
    r.status     = st;
    r.slot_index = slot;
    r.last       = 1'b1;
    return r;
  endfunction

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign in_addr   = slot_addr(in_item.reply_slot);
  assign rpl_addr  = slot_addr(item_r.reply_slot);
  assign due       = chk_v_r && valid_r[chk_idx_r] && !pend_r[chk_idx_r] &&
                     (mem_rdata.run_time < item_r.time_value);
  assign stall     = due && hold_v_r && !res_ready;
  assign scan_done = !chk_v_r && (scan_ptr_r == CNT_W'(SLOTS));
  assign keep      = (mem_rdata.retries != RETRY_ONCE) && (item_r.time_value != '0);
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    due_res                = '0;
    due_res.status         = ST_DUE;
    due_res.slot_index     = 2'(chk_idx_r);
    due_res.due_handle     = mem_rdata.handle;
    due_res.scheduled_time = mem_rdata.run_time;
    due_res.due_data       = mem_rdata.data;
    due_res.last           = 1'b0;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    res_nxt      = res_r;
    hold_v_nxt   = hold_v_r;
    scan_ptr_nxt = scan_ptr_r;
    chk_v_nxt    = chk_v_r;
    chk_idx_nxt  = chk_idx_r;
    valid_nxt    = valid_r;
    pend_nxt     = pend_r;
    res_push     = 1'b0;
    res          = res_r;
    mem_wr       = '0;
    mem_rd       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          unique case (in_item.kind)
            KIND_SUBMIT: begin
              if (free_found) begin
                mem_wr.we             = 1'b1;
                mem_wr.addr           = free_idx;
                mem_wr.entry.run_time = in_item.time_value;
                mem_wr.entry.retries  = in_item.retry_count;
                mem_wr.entry.handle   = in_item.task_handle;
                mem_wr.entry.data     = in_item.task_data;
                valid_nxt[free_idx]   = 1'b1;
                pend_nxt[free_idx]    = 1'b0;
                res_nxt = mk_result(ST_ACCEPTED, 2'(free_idx));
              end else begin
                res_nxt = mk_result(ST_FULL, 2'd0);
              end
              state_nxt = S_EMIT;
            end
            KIND_TICK: begin
              scan_ptr_nxt = '0;
              chk_v_nxt    = 1'b0;
              hold_v_nxt   = 1'b0;
              state_nxt    = S_SCAN;
            end
            KIND_REPLY: begin
              if (slot_in_range(in_item.reply_slot) && valid_r[in_addr] && pend_r[in_addr]) begin
                mem_rd.re   = 1'b1;
                mem_rd.addr = in_addr;
                state_nxt   = S_RPL_WR;
              end else begin
                res_nxt   = mk_result(ST_IGNORED, in_item.reply_slot);
                state_nxt = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // a new due slot pushes out the one held before it
        if (due && hold_v_r) begin
          res_push = 1'b1;
          res      = res_r;
        end
        if (!stall) begin
          if (due) begin
            pend_nxt[chk_idx_r] = 1'b1;
            res_nxt             = due_res;
            hold_v_nxt          = 1'b1;
          end
          if (scan_ptr_r < CNT_W'(SLOTS)) begin
            mem_rd.re    = 1'b1;
            mem_rd.addr  = scan_ptr_r[IDX_W-1:0];
            scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
            chk_v_nxt    = 1'b1;
            chk_idx_nxt  = scan_ptr_r[IDX_W-1:0];
          end else begin
            chk_v_nxt = 1'b0;
          end
        end
        if (scan_done) begin
          res_push = 1'b1;
          if (hold_v_r) begin
            res      = res_r;
            res.last = 1'b1;
          end else begin
            res = mk_result(ST_NONE_DUE, 2'd0);
          end
          if (res_ready) begin
            hold_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_RPL_WR: begin
        mem_wr.we             = 1'b1;
        mem_wr.addr           = rpl_addr;
        mem_wr.entry.run_time = keep ? item_r.time_value : mem_rdata.run_time;
        mem_wr.entry.retries  = (keep && (mem_rdata.retries != '0)) ?
                                (mem_rdata.retries - 16'd1) : mem_rdata.retries;
        mem_wr.entry.handle   = mem_rdata.handle;
        mem_wr.entry.data     = item_r.task_data;
        pend_nxt[rpl_addr]    = 1'b0;
        if (keep) begin
          res_nxt = mk_result(ST_RESCHED, item_r.reply_slot);
        end else begin
          valid_nxt[rpl_addr] = 1'b0;
          res_nxt = mk_result(ST_DELETED, item_r.reply_slot);
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        res_push = 1'b1;
        res      = res_r;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    res_r     <= res_nxt;
    chk_idx_r <= chk_idx_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      hold_v_r   <= 1'b0;
      scan_ptr_r <= '0;
      chk_v_r    <= 1'b0;
      valid_r    <= '0;
      pend_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      hold_v_r   <= hold_v_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      chk_v_r    <= chk_v_nxt;
      valid_r    <= valid_nxt;
      pend_r     <= pend_nxt;
    end
  end

`ifndef SYNTH
  a_pend_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~valid_r) == '0)
    else $error("pending set on a free slot");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_wr.we)
    else $error("slot memory written during tick scan");

  a_hold_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("due result left held after scan");

  a_scan_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && res_push && !scan_done) |-> !res.last)
    else $error("last flagged before scan end");
`endif

endmodule

// ===== sv/timed_task_slot_table.sv =====
// Top level of the timed task slot table: stream ports, sequencer, slot memory, output register.
//
// The table holds SLOTS task slots (run time, retry count, handle, private data)
// in a single-port-read, single-port-write memory; the valid and pending flags
// sit in flip-flops and are cleared by reset, the memory itself needs no clearing.
// One item is worked on at a time. A submit takes the lowest free slot and gives
// one result (accepted, or table full) through the emit state. A reply reads its
// slot, then writes it back rescheduled or freed, and gives one result; a reply
// naming a free, non-pending or absent slot skips the memory and is answered
// "ignored" through the emit state, like a submit. A tick walks the slots through
// the memory read port, one slot per cycle when not stalled, and gives one due
// result per expired, non-pending slot (marking it pending), with tlast on the
// final one, or a single "none due" result. Kind 3 is dropped with no result.
// Results pass through an output register, so the next item is taken while a
// result waits; the walk only stalls when a new due slot finds a result held and the output register full.
module timed_task_slot_table import tts_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] time_value, [47:32] retry_count, [63:48] task_handle,
  // [95:64] task_data, [97:96] reply_slot, [103:98] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] slot_index, [17:2] due_handle, [49:18] scheduled_time,
  // [81:50] due_data, [87:82] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  item_t       in_item;
  logic        res_ready;
  logic        res_push;
  result_t     res;
  mem_wr_t     mem_wr;
  mem_rd_t     mem_rd;
  slot_entry_t mem_rdata;

  result_t     out_r, out_nxt;
  logic        out_v_r, out_v_nxt;

  // unpack the input item
  assign in_item.kind        = in_tuser;
  assign in_item.time_value  = in_tdata[31:0];
  assign in_item.retry_count = in_tdata[47:32];
  assign in_item.task_handle = in_tdata[63:48];
  assign in_item.task_data   = in_tdata[95:64];
  assign in_item.reply_slot  = in_tdata[97:96];

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_item   (in_item),
    .in_ready  (in_tready),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .mem_rdata (mem_rdata)
  );

  tts_slot_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_v_r || out_tready;

  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (res_push && res_ready) begin
      out_nxt   = res;
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {6'd0, out_r.due_data, out_r.scheduled_time,
                       out_r.due_handle, out_r.slot_index};

endmodule

// ===== tb/sv/timed_task_slot_table_test.sv =====
// Self-checking testbench for the timed task slot table: directed and random stream traffic.
`timescale 1ns / 100ps

module timed_task_slot_table_test;
  import tts_pkg::*;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;   // dropped by the block, no result
  localparam int         WATCHDOG_LIMIT = 2000;   // cycles without any handshake
  localparam int         DRAIN_CYCLES   = 4 * SLOTS + 16;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [31:0] time_value, [47:32] retry_count, [63:48] task_handle,
  // [95:64] task_data, [97:96] reply_slot, [103:98] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [1:0] kind
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [1:0] slot_index, [17:2] due_handle, [49:18] scheduled_time,
  // [81:50] due_data, [87:82] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  // [2:0] status
  logic [2:0]             out_tuser;
  logic                   out_tlast;

  // Shadow copy of the slot table, updated at each accepted item.
  logic        tbl_valid   [SLOTS];
  logic        tbl_pending [SLOTS];
  logic [31:0] tbl_time    [SLOTS];
  logic [15:0] tbl_retries [SLOTS];
  logic [15:0] tbl_handle  [SLOTS];
  logic [31:0] tbl_data    [SLOTS];

  result_t     awaited_answers[$];

  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          mismatches;
  int          quiet_cycles;
  int          n_submit, n_tick, n_reply, n_dropped, n_results, n_due;
  logic [31:0] clock_now;   // software time used to build sensible ticks

  timed_task_slot_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stalls at random according to the current idling phase.
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Applies one accepted item to the shadow table and queues the answers it causes.
  task automatic slot_table_step(input logic [1:0] kind, input logic [31:0] tv,
                                 input logic [15:0] rc, input logic [15:0] th,
                                 input logic [31:0] td, input logic [1:0] rs);
    result_t r;
    bit      hit;
    hit  = 1'b0;
    r    = '0;
    r.last = 1'b1;
    case (kind)
      KIND_SUBMIT: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && !tbl_valid[i]) begin
            hit            = 1'b1;
            tbl_valid[i]   = 1'b1;
            tbl_pending[i] = 1'b0;
            tbl_time[i]    = tv;
            tbl_retries[i] = rc;
            tbl_handle[i]  = th;
            tbl_data[i]    = td;
            r.status       = ST_ACCEPTED;
            r.slot_index   = 2'(i);
          end
        end
        awaited_answers.push_back(r);
      end
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && !tbl_pending[i] && tbl_time[i] < tv) begin
            hit              = 1'b1;
            tbl_pending[i]   = 1'b1;
            r.status         = ST_DUE;
            r.slot_index     = 2'(i);
            r.due_handle     = tbl_handle[i];
            r.scheduled_time = tbl_time[i];
            r.due_data       = tbl_data[i];
            r.last           = 1'b0;
            awaited_answers.push_back(r);
          end
        end
        if (!hit) begin
          r.status = ST_NONE_DUE;
          awaited_answers.push_back(r);
        end else begin
          // tlast goes on the final due answer of the scan
          r = awaited_answers.pop_back();
          r.last = 1'b1;
          awaited_answers.push_back(r);
        end
      end
      KIND_REPLY: begin
        r.slot_index = rs;
        if (int'(rs) >= SLOTS || !tbl_valid[rs] || !tbl_pending[rs]) begin
          r.status = ST_IGNORED;
        end else begin
          tbl_pending[rs] = 1'b0;
          tbl_data[rs]    = td;
          if (tbl_retries[rs] != RETRY_ONCE && tv != 32'd0) begin
            tbl_time[rs] = tv;
            if (tbl_retries[rs] != 16'd0) tbl_retries[rs] = tbl_retries[rs] - 16'd1;
            r.status = ST_RESCHED;
          end else begin
            tbl_valid[rs] = 1'b0;
            r.status = ST_DELETED;
          end
        end
        awaited_answers.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Prediction at input handshakes, then comparison at output handshakes.
  // A result can never leave in the cycle its item is taken, so order here is safe.
  always @(posedge clk) begin : answer_check
    result_t got;
    result_t want;
    if (rst_n && in_tvalid && in_tready) begin
      case (in_tuser)
        KIND_SUBMIT: n_submit++;
        KIND_TICK:   n_tick++;
        KIND_REPLY:  n_reply++;
        default:     n_dropped++;
      endcase
      slot_table_step(in_tuser, in_tdata[31:0], in_tdata[47:32], in_tdata[63:48],
                      in_tdata[95:64], in_tdata[97:96]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status         = status_t'(out_tuser);
      got.slot_index     = out_tdata[1:0];
      got.due_handle     = out_tdata[17:2];
      got.scheduled_time = out_tdata[49:18];
      got.due_data       = out_tdata[81:50];
      got.last           = out_tlast;
      n_results++;
      if (got.status == ST_DUE) n_due++;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual status %0d slot %0d",
                 $time, out_tuser, out_tdata[1:0]);
      end else begin
        want = awaited_answers.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
        compare_field("due_handle", 32'(want.due_handle), 32'(got.due_handle));
        compare_field("scheduled_time", want.scheduled_time, got.scheduled_time);
        compare_field("due_data", want.due_data, got.due_data);
        compare_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one item. Entered and left at a falling edge; valid stays high into the
  // next call unless that call opens with an idle gap.
  task automatic send_item(input logic [1:0] kind, input logic [31:0] tv,
                           input logic [15:0] rc, input logic [15:0] th,
                           input logic [31:0] td, input logic [1:0] rs);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, rs, td, th, rc, tv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Four submits, two at the field extremes, fill the table; a fifth finds it full.
  task automatic test_fill_and_full;
    send_item(KIND_SUBMIT, 32'h0000_0000, 16'h0000, 16'h0000, 32'h0000_0000, 2'd0);
    send_item(KIND_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send_item(KIND_SUBMIT, 32'd5, RETRY_ONCE, 16'h1234, 32'hA5A5_5A5A, 2'd1);
    send_item(KIND_SUBMIT, 32'd7, 16'd2, 16'h8001, 32'h0F0F_F0F0, 2'd2);
    send_item(KIND_SUBMIT, 32'd1, 16'd3, 16'h7FFE, 32'h1234_5678, 2'd0);
  endtask

  // Tick at zero finds nothing; a tick at the top of the range takes every slot
  // below it; a repeat skips the pending slots and the one at the top.
  task automatic test_tick_scan;
    send_item(KIND_TICK, 32'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send_item(KIND_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0, 32'd0, 2'd0);
    send_item(KIND_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0, 32'd0, 2'd0);
  endtask

  // Each reply outcome: ignored on a slot that is not pending, reschedule with
  // unlimited retries, free on a one-shot task, free on a zero next time, ignored
  // on a freed slot; then the unused kind, reuse of the lowest free slot and a
  // tick that catches the rescheduled task.
  task automatic test_reply_outcomes;
    send_item(KIND_REPLY, 32'd100, 16'd0, 16'd0, 32'hDEAD_BEEF, 2'd1);
    send_item(KIND_REPLY, 32'd100, 16'd0, 16'd0, 32'hCAFE_0001, 2'd0);
    send_item(KIND_REPLY, 32'd50, 16'd0, 16'd0, 32'h0000_0002, 2'd2);
    send_item(KIND_REPLY, 32'd0, 16'd0, 16'd0, 32'h0000_0003, 2'd3);
    send_item(KIND_REPLY, 32'd9, 16'd0, 16'd0, 32'h0000_0004, 2'd2);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send_item(KIND_SUBMIT, 32'd10, 16'd4, 16'h0042, 32'h5555_AAAA, 2'd1);
    send_item(KIND_TICK, 32'd200, 16'd0, 16'd0, 32'd0, 2'd0);
  endtask

  // Mostly well-formed traffic: submits near the current time, ticks that move
  // time forward, replies to slots that are actually pending. The rest is noise:
  // replies to any slot, stray tick times and the unused kind.
  task automatic test_random_traffic(input int n_items);
    logic [1:0]  kind;
    logic [1:0]  rs;
    logic [31:0] tv;
    logic [31:0] td;
    logic [15:0] rc;
    logic [15:0] th;
    logic [1:0]  waiting[$];
    int          done;
    int          pick;
    done = 0;
    while (done < n_items) begin
      kind = 2'($urandom);
      tv   = $urandom;
      td   = $urandom;
      rc   = 16'($urandom);
      th   = 16'($urandom);
      rs   = 2'($urandom);
      waiting.delete();
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i] && tbl_pending[i]) waiting.push_back(2'(i));
      end
      pick = $urandom_range(99);
      if (waiting.size() > 0 && pick < 40) begin
        kind = KIND_REPLY;
        rs   = waiting[$urandom_range(waiting.size() - 1)];
        case ($urandom_range(3))
          0:       tv = 32'd0;
          1, 2:    tv = clock_now + 32'($urandom_range(1, 60));
          default: ;
        endcase
      end else if (pick < 65) begin
        kind = KIND_SUBMIT;
        case ($urandom_range(4))
          0:       rc = 16'd0;
          1:       rc = RETRY_ONCE;
          2:       rc = 16'($urandom_range(2, 4));
          default: ;
        endcase
        if ($urandom_range(3) != 0) tv = clock_now + 32'($urandom_range(0, 80)) - 32'd20;
      end else if (pick < 88) begin
        kind = KIND_TICK;
        clock_now = clock_now + 32'($urandom_range(0, 40));
        if ($urandom_range(9) != 0) tv = clock_now;
      end else if (pick < 95) begin
        kind = KIND_REPLY;
      end else begin
        kind = KIND_UNUSED;
      end
      send_item(kind, tv, rc, th, td, rs);
      if (kind != KIND_UNUSED) done++;
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    in_tuser           = '0;
    out_tready         = 1'b0;
    mismatches         = 0;
    quiet_cycles       = 0;
    n_submit           = 0;
    n_tick             = 0;
    n_reply            = 0;
    n_dropped          = 0;
    n_results          = 0;
    n_due              = 0;
    clock_now          = $urandom;
    sender_idle_pct    = 34;
    receiver_stall_pct = 71;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_pending[i] = 1'b0;
      tbl_time[i]    = '0;
      tbl_retries[i] = '0;
      tbl_handle[i]  = '0;
      tbl_data[i]    = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_full();
    test_tick_scan();
    test_reply_outcomes();
    test_random_traffic(75);
    sender_idle_pct    = 71;
    receiver_stall_pct = 34;
    test_random_traffic(75);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_traffic(75);
    in_tvalid <= 1'b0;

    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d submits, %0d ticks, %0d replies and %0d unused-kind items",
             n_submit, n_tick, n_reply, n_dropped);
    $display("Checked %0d results, %0d of them due tasks; %0d field mismatches",
             n_results, n_due, mismatches);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
